[rtl/gcl_pkg.sv]
package gcl_pkg;

  // Default node capacity of the labeler
  localparam int GclMaxNodes = 8;

  // Stream field widths
  localparam int GraphWordW = 28;
  localparam int CanonWordW = 28;
  localparam int PermDigitsW = 24;
  localparam int PermIndexW = 16;
  localparam int DigitStride = 3;
  localparam int InTdataW = 32;
  localparam int OutFieldsW = CanonWordW + PermDigitsW + PermIndexW + 1;
  localparam int OutTdataW = ((OutFieldsW + 7) / 8) * 8;

  // Configuration register map
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CfgNodeCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLowerOrder = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInvertPerm = 2'd2;
  localparam logic [CfgDataW-1:0] NodeCountReset = 4'd8;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SCAN_MIN,
    ST_SCAN_MATCH,
    ST_DONE
  } gcl_state_e;

  // n! for elaboration-time sizing
  function automatic int gcl_fact(input int n);
    int f;
    f = 1;
    for (int x = 2; x <= n; x++) begin
      f = f * x;
    end
    return f;
  endfunction

endpackage

[rtl/graph_canonical_labeler_unit.sv]
// Canonical labeler for small undirected graphs.
// Input stream: one request is one adjacency word (k*(k-1)/2 bits used,
// first node pair in the top used bit). Output stream: one result with
// the canonical word, the relabeling permutation, its lexicographic rank
// and a flag that the input was already canonical.
// Configuration (node count, triangle order, permutation inversion) is
// written through the plain write port while no request is in flight;
// the user must keep to that, as the block itself does not enforce it.
// Per request the sequencer builds the pair table and adjacency matrix,
// runs the minimum search, reloads the matrix, runs the match search and
// loads the output register.
// Both searches run on the same combinational relabel and successor
// units, so one permutation is handled per cycle; s_axis_tready is high
// only while the sequencer is idle.
// A result waits in the output register while m_axis_tready is low; the
// next request is taken meanwhile, and its result waits in the last step
// until the register frees. Reset clears the configuration to k = 8,
// upper triangle, direct permutation, and drops any pending result.
module graph_canonical_labeler_unit import gcl_pkg::*; #(
  parameter int MAX_NODES = GclMaxNodes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,  // [27:0] graph_word
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata   // [27:0] canonical_word,
                                              // [51:28] perm_digits,
                                              // [67:52] perm_index,
                                              // [68] is_canonical
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int KW    = $clog2(MAX_NODES + 1);
  localparam int PAIRS = (MAX_NODES * (MAX_NODES - 1)) / 2;
  localparam int NPW   = $clog2(PAIRS);
  localparam int PCW   = $clog2(PAIRS + 1);
  localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
  localparam int CNT_W = $clog2(gcl_fact(MAX_NODES));
  localparam int WW    = (PAIRS > GraphWordW) ? PAIRS : GraphWordW;
  localparam int DIGW  = (DigitStride * MAX_NODES + NW > PermDigitsW) ?
                         DigitStride * MAX_NODES + NW : PermDigitsW;
  localparam int IDXW  = (CNT_W > PermIndexW) ? CNT_W : PermIndexW;

  typedef logic [MAX_NODES-1:0][NW-1:0] perm_t;

  // configuration registers
  logic [CfgDataW-1:0] node_count_q;
  logic                lower_q;
  logic                invert_q;

  // sequencer and datapath registers
  gcl_state_e state_q, state_d;
  perm_t            perm_q, perm_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pass_q, pass_d;
  logic [PAIRS-1:0] best_q, best_d;
  logic [PAIRS-1:0] lin_q, lin_d;
  logic [KW-1:0]    k_q, k_d;
  logic [PCW-1:0]   npairs_q, npairs_d;
  logic [NPW-1:0]   n_q, n_d;
  logic [NW-1:0]    i_q, i_d, j_q, j_d;
  logic [NW-1:0]    pa_q [PAIRS];
  logic [NW-1:0]    pb_q [PAIRS];
  logic [MAX_NODES*MAX_NODES-1:0] adj_q;
  logic                  m_valid_q, m_valid_d;
  logic [OutFieldsW-1:0] out_q, out_d;

  // control strobes
  logic in_accept;
  logic walk_we;
  logic walk_last;
  logic out_free;
  logic match;

  // combinational helpers
  logic [KW-1:0]    k_eff;
  logic [PCW-1:0]   npairs_eff;
  logic [PAIRS-1:0] lin_eff;
  perm_t            ident;
  perm_t            step_perm;
  logic             step_valid;
  logic [PAIRS-1:0] rel;
  logic             src_bit;
  perm_t            inv_perm;
  logic [DIGW-1:0]  digits;
  logic [PAIRS-1:0] canon_l;
  logic [WW-1:0]    canon_w;
  logic [IDXW-1:0]  idx_w;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
      lower_q      <= 1'b0;
      invert_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNodeCount:  node_count_q <= cfg_data_i;
        CfgLowerOrder: lower_q      <= cfg_data_i[0];
        CfgInvertPerm: invert_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamped node count, pair count and left-aligned input word
  always_comb begin
    int kk;
    logic [WW-1:0] word;
    logic [WW-1:0] mask;
    if (node_count_q < CfgDataW'(2)) begin
      k_eff = KW'(2);
    end else if (int'(node_count_q) > MAX_NODES) begin
      k_eff = KW'(MAX_NODES);
    end else begin
      k_eff = KW'(node_count_q);
    end
    kk         = int'(k_eff);
    npairs_eff = PCW'((kk * (kk - 1)) >> 1);
    mask       = (WW'(1) << npairs_eff) - WW'(1);
    word       = WW'(s_axis_tdata[GraphWordW-1:0]) & mask;
    lin_eff    = PAIRS'(word << (PCW'(PAIRS) - npairs_eff));
  end

  // identity permutation on k nodes, zeros above
  always_comb begin
    for (int x = 0; x < MAX_NODES; x++) begin
      ident[x] = (x < k_q) ? NW'(x) : '0;
    end
  end

  // shared relabel unit: one permuted word per cycle, left aligned
  always_comb begin
    logic [NW-1:0] a;
    logic [NW-1:0] b;
    rel = '0;
    for (int lf = 0; lf < PAIRS; lf++) begin
      a = perm_q[pa_q[lf]];
      b = perm_q[pb_q[lf]];
      rel[PAIRS-1-lf] = (lf < npairs_q) &&
                        adj_q[AW'(int'(a) * MAX_NODES + int'(b))];
    end
  end

  // shared successor unit
  gcl_perm_step #(
    .MAX_NODES (MAX_NODES)
  ) u_perm_step (
    .perm_i  (perm_q),
    .k_i     (k_q),
    .perm_o  (step_perm),
    .valid_o (step_valid)
  );

  assign match     = (rel == lin_q);
  assign walk_last = (PCW'(n_q) == npairs_q - PCW'(1));
  assign out_free  = !m_valid_q || m_axis_tready;
  assign src_bit   = pass_q ? best_q[NPW'(PAIRS - 1) - n_q] : lin_q[NPW'(PAIRS - 1) - n_q];

  // inverse permutation and packed digits
  always_comb begin
    logic [NW-1:0] val;
    inv_perm = '0;
    for (int q = 0; q < MAX_NODES; q++) begin
      for (int p = 0; p < MAX_NODES; p++) begin
        if (p < k_q && perm_q[p] == NW'(q)) begin
          inv_perm[q] = NW'(p);
        end
      end
    end
    digits = '0;
    for (int p = 0; p < MAX_NODES; p++) begin
      val = invert_q ? inv_perm[p] : perm_q[p];
      if (p < k_q) begin
        digits = digits | (DIGW'(val) << (DigitStride * p));
      end
    end
  end

  // right-aligned canonical word and rank, sized to the output fields
  assign canon_l = best_q >> (PCW'(PAIRS) - npairs_q);
  assign canon_w = WW'(canon_l);
  assign idx_w   = IDXW'(cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_last) state_d = pass_q ? ST_SCAN_MATCH : ST_SCAN_MIN;
      end
      ST_SCAN_MIN: begin
        if (!step_valid) state_d = ST_WALK;
      end
      ST_SCAN_MATCH: begin
        if (match || !step_valid) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    s_axis_tready = 1'b0;
    in_accept     = 1'b0;
    walk_we       = 1'b0;
    perm_d        = perm_q;
    cnt_d         = cnt_q;
    pass_d        = pass_q;
    best_d        = best_q;
    lin_d         = lin_q;
    k_d           = k_q;
    npairs_d      = npairs_q;
    n_d           = n_q;
    i_d           = i_q;
    j_d           = j_q;
    out_d         = out_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          in_accept = 1'b1;
          k_d       = k_eff;
          npairs_d  = npairs_eff;
          lin_d     = lin_eff;
          pass_d    = 1'b0;
          n_d       = '0;
          i_d       = lower_q ? NW'(1) : '0;
          j_d       = lower_q ? '0 : NW'(1);
        end
      end
      ST_WALK: begin
        walk_we = 1'b1;
        n_d     = n_q + NPW'(1);
        if (lower_q) begin
          if (j_q == i_q - NW'(1)) begin
            i_d = i_q + NW'(1);
            j_d = '0;
          end else begin
            j_d = j_q + NW'(1);
          end
        end else begin
          if (KW'(j_q) == k_q - KW'(1)) begin
            i_d = i_q + NW'(1);
            j_d = i_q + NW'(2);
          end else begin
            j_d = j_q + NW'(1);
          end
        end
        if (walk_last) begin
          perm_d = ident;
          cnt_d  = '0;
        end
      end
      ST_SCAN_MIN: begin
        if (cnt_q == '0 || rel < best_q) best_d = rel;
        if (step_valid) begin
          perm_d = step_perm;
          cnt_d  = cnt_q + CNT_W'(1);
        end else begin
          pass_d = 1'b1;
          n_d    = '0;
          i_d    = lower_q ? NW'(1) : '0;
          j_d    = lower_q ? '0 : NW'(1);
        end
      end
      ST_SCAN_MATCH: begin
        if (!match) begin
          if (step_valid) begin
            perm_d = step_perm;
            cnt_d  = cnt_q + CNT_W'(1);
          end else begin
            perm_d = ident;
            cnt_d  = '0;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          out_d     = {lin_q == best_q, idx_w[PermIndexW-1:0],
                       digits[PermDigitsW-1:0], canon_w[CanonWordW-1:0]};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      for (int x = 0; x < MAX_NODES; x++) perm_q[x] <= NW'(x);
      cnt_q     <= '0;
      pass_q    <= 1'b0;
      best_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      perm_q    <= perm_d;
      cnt_q     <= cnt_d;
      pass_q    <= pass_d;
      best_q    <= best_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lin_q    <= lin_d;
    k_q      <= k_d;
    npairs_q <= npairs_d;
    n_q      <= n_d;
    i_q      <= i_d;
    j_q      <= j_d;
    out_q    <= out_d;
    if (walk_we) begin
      pa_q[n_q] <= i_q;
      pb_q[n_q] <= j_q;
      adj_q[AW'(int'(i_q) * MAX_NODES + int'(j_q))] <= src_bit;
      adj_q[AW'(int'(j_q) * MAX_NODES + int'(i_q))] <= src_bit;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutTdataW'(out_q);

`ifndef SYNTH
  // a request starts the table walk of the first pass
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_WALK && !pass_q)
    else $error("accepted request did not start the first walk");

  // exhausting the minimum search reloads the matrix for the second pass
  a_min_to_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN_MIN && !step_valid |=> state_q == ST_WALK && pass_q)
    else $error("minimum search did not hand over to the second pass");

  // a canonical input is always reported at rank zero
  a_canon_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[68] |-> m_axis_tdata[67:52] == '0)
    else $error("canonical input reported with nonzero rank");

  // a new result only comes out of the final step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the final step");
`endif

endmodule

[rtl/gcl_perm_step.sv]
// Lexicographic successor of a permutation of 0..k-1, computed combinationally
module gcl_perm_step import gcl_pkg::*; #(
  parameter int MAX_NODES = GclMaxNodes
) (
  input  logic [MAX_NODES-1:0][$clog2(MAX_NODES)-1:0] perm_i,
  input  logic [$clog2(MAX_NODES+1)-1:0]              k_i,
  output logic [MAX_NODES-1:0][$clog2(MAX_NODES)-1:0] perm_o,
  output logic                                        valid_o
);

  localparam int NW = $clog2(MAX_NODES);

  logic [NW-1:0] piv;
  logic [NW-1:0] swp;
  logic [NW-1:0] pv;
  logic          found;
  logic [MAX_NODES-1:0][NW-1:0] swapped;

  // Rightmost ascent and rightmost digit above the pivot value
  always_comb begin
    found = 1'b0;
    piv   = '0;
    for (int i = 1; i < MAX_NODES; i++) begin
      if (i < k_i && perm_i[i] > perm_i[i-1]) begin
        found = 1'b1;
        piv   = NW'(i);
      end
    end
    pv  = perm_i[piv - NW'(1)];
    swp = piv;
    for (int j = 1; j < MAX_NODES; j++) begin
      if (j < k_i && NW'(j) >= piv && perm_i[j] > pv) begin
        swp = NW'(j);
      end
    end
  end

  // Swap, then reverse the tail from the pivot to k-1
  always_comb begin
    int src;
    swapped = perm_i;
    swapped[piv - NW'(1)] = perm_i[swp];
    swapped[swp] = pv;
    for (int x = 0; x < MAX_NODES; x++) begin
      src = int'(piv) + int'(k_i) - 1 - x;
      if (NW'(x) >= piv && x < k_i) begin
        perm_o[x] = swapped[NW'(src)];
      end else begin
        perm_o[x] = swapped[x];
      end
    end
  end

  assign valid_o = found;

endmodule

[tb/tb_graph_canonical_labeler_unit.sv]
module tb_graph_canonical_labeler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gcl_pkg::*;

  // Register index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;
  // The limit is several times the slowest legal run (three k = 8 requests
  // plus every random request at k = 7).
  localparam int CycleLimit = 6_000_000;
  localparam int SettleCycles = 16;
  localparam int NodeBits = GclMaxNodes * GclMaxNodes;

  // Result fields, packed as on m_axis_tdata
  typedef struct packed {
    logic                   is_canon;
    logic [PermIndexW-1:0]  rank;
    logic [PermDigitsW-1:0] digits;
    logic [CanonWordW-1:0]  canon;
  } label_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;   // [27:0] graph_word
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // [27:0] canonical_word,
                                             // [51:28] perm_digits,
                                             // [67:52] perm_index,
                                             // [68] is_canonical

  // Copy of the configuration as last written
  logic [CfgDataW-1:0] node_count_q = NodeCountReset;
  logic                lower_order_q = 1'b0;
  logic                invert_perm_q = 1'b0;

  int     idle_pct = 13;
  int     mismatch_count = 0;
  int     cycle_count = 0;
  label_t pending_labels[$];

  graph_canonical_labeler_unit #(
    .MAX_NODES(GclMaxNodes)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Labeling predictor
  // ---------------------------------------------------------------------

  // node count register to nodes in use, clamped to 2..max
  function automatic int live_nodes(input logic [CfgDataW-1:0] nc);
    int k;
    k = nc;
    if (k < 2) k = 2;
    if (k > GclMaxNodes) k = GclMaxNodes;
    return k;
  endfunction

  function automatic logic [GraphWordW-1:0] pair_mask(input logic [CfgDataW-1:0] nc);
    int k;
    k = live_nodes(nc);
    return GraphWordW'((64'd1 << (k * (k - 1) / 2)) - 64'd1);
  endfunction

  // adjacency matrix of a word, first pair in the top used bit
  function automatic logic [NodeBits-1:0] adjacency(input logic [GraphWordW-1:0] word,
                                                    input int k, input logic lower);
    logic [NodeBits-1:0] adj;
    int bpos;
    adj = '0;
    bpos = k * (k - 1) / 2 - 1;
    for (int i = 0; i < k; i++) begin
      for (int j = 0; j < k; j++) begin
        if (lower ? (j < i) : (j > i)) begin
          adj[GclMaxNodes * i + j] = word[bpos];
          adj[GclMaxNodes * j + i] = word[bpos];
          bpos--;
        end
      end
    end
    return adj;
  endfunction

  // word after relabeling: pair (i,j) takes adjacency of (order[i],order[j])
  function automatic logic [GraphWordW-1:0] relabel(input logic [PermDigitsW-1:0] order,
                                                    input logic [NodeBits-1:0] adj,
                                                    input int k, input logic lower);
    logic [GraphWordW-1:0] w;
    int bpos, a, b;
    w = '0;
    bpos = k * (k - 1) / 2 - 1;
    for (int i = 0; i < k; i++) begin
      for (int j = 0; j < k; j++) begin
        if (lower ? (j < i) : (j > i)) begin
          a = order[DigitStride * i +: DigitStride];
          b = order[DigitStride * j +: DigitStride];
          w[bpos] = adj[GclMaxNodes * a + b];
          bpos--;
        end
      end
    end
    return w;
  endfunction

  // lexicographic successor; returns 0 and leaves the order alone at the last one
  function automatic logic next_order(input logic [PermDigitsW-1:0] cur, input int k,
                                      output logic [PermDigitsW-1:0] nxt);
    int d[GclMaxNodes];
    int i, j, t;
    logic found;
    for (int x = 0; x < GclMaxNodes; x++) d[x] = cur[DigitStride * x +: DigitStride];
    found = 1'b0;
    i = k - 1;
    while (i > 0 && !found) begin
      if (d[i] > d[i - 1]) found = 1'b1;
      else i--;
    end
    if (found) begin
      j = k - 1;
      while (d[j] <= d[i - 1]) j--;
      t = d[i - 1]; d[i - 1] = d[j]; d[j] = t;
      j = k - 1;
      while (i < j) begin
        t = d[i]; d[i] = d[j]; d[j] = t;
        i++;
        j--;
      end
    end
    nxt = '0;
    for (int x = 0; x < k; x++) nxt[DigitStride * x +: DigitStride] = DigitStride'(d[x]);
    return found;
  endfunction

  function automatic label_t label_graph(input logic [GraphWordW-1:0] graph,
                                         input logic [CfgDataW-1:0] nc,
                                         input logic lower, input logic invert);
    label_t                 res;
    logic [GraphWordW-1:0]  word, best, trial;
    logic [NodeBits-1:0]    adj;
    logic [PermDigitsW-1:0] start, order, digits;
    logic                   more, found;
    int                     k, rank, slot;
    k = live_nodes(nc);
    word = graph & pair_mask(nc);
    start = '0;
    for (int x = 0; x < k; x++) start[DigitStride * x +: DigitStride] = DigitStride'(x);

    // minimum over every relabeling
    adj = adjacency(word, k, lower);
    order = start;
    best = relabel(order, adj, k, lower);
    more = 1'b1;
    while (more) begin
      more = next_order(order, k, order);
      if (more) begin
        trial = relabel(order, adj, k, lower);
        if (trial < best) best = trial;
      end
    end

    // first relabeling that takes the canonical word back to the input
    adj = adjacency(best, k, lower);
    order = start;
    rank = 0;
    found = 1'b0;
    more = 1'b1;
    while (!found && more) begin
      if (relabel(order, adj, k, lower) == word) begin
        found = 1'b1;
      end else begin
        more = next_order(order, k, order);
        if (more) rank++;
      end
    end
    if (!found) begin
      order = start;
      rank = 0;
    end

    digits = '0;
    for (int p = 0; p < k; p++) begin
      slot = order[DigitStride * p +: DigitStride];
      if (invert) digits[DigitStride * slot +: DigitStride] = DigitStride'(p);
      else digits[DigitStride * p +: DigitStride] = DigitStride'(slot);
    end

    res.canon = best;
    res.digits = digits;
    res.rank = PermIndexW'(rank);
    res.is_canon = (word == best);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------

  // one register write; starts and ends on a falling edge
  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgNodeCount: begin
        node_count_q = val;
      end
      CfgLowerOrder: begin
        lower_order_q = val[0];
      end
      CfgInvertPerm: begin
        invert_perm_q = val[0];
      end
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input logic [CfgDataW-1:0] nc, input logic lower,
                           input logic invert);
    set_reg(CfgNodeCount, nc);
    set_reg(CfgLowerOrder, {3'b000, lower});
    set_reg(CfgInvertPerm, {3'b000, invert});
  endtask

  // one request; tvalid is left high so back-to-back requests need no toggle
  task automatic send_graph(input logic [GraphWordW-1:0] word);
    label_t want;
    want = label_graph(word, node_count_q, lower_order_q, invert_perm_q);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= InTdataW'(word);
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_labels.push_back(want);
    @(negedge clk_i);
  endtask

  // stop sending and let every pending result come back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_labels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h, cycle %0d",
             field, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    label_t got;
    label_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = label_t'(m_axis_tdata[OutFieldsW-1:0]);
      if (pending_labels.size() == 0) begin
        flag_mismatch("result with no request pending", 32'(got.canon), '0);
      end else begin
        want = pending_labels.pop_front();
        if (got.canon !== want.canon) begin
          flag_mismatch("canonical_word", 32'(got.canon), 32'(want.canon));
        end
        if (got.digits !== want.digits) begin
          flag_mismatch("perm_digits", 32'(got.digits), 32'(want.digits));
        end
        if (got.rank !== want.rank) begin
          flag_mismatch("perm_index", 32'(got.rank), 32'(want.rank));
        end
        if (got.is_canon !== want.is_canon) begin
          flag_mismatch("is_canonical", 32'(got.is_canon), 32'(want.is_canon));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // eight nodes, upper order, direct permutation straight out of reset
  task automatic test_reset_defaults;
    send_graph(GraphWordW'($urandom));
    drain();
  endtask

  // node counts below 2 act as 2, above the maximum as the maximum
  task automatic test_node_count_clamp;
    configure(4'd0, 1'b0, 1'b0);
    send_graph('0);
    send_graph('1);
    drain();
    configure(4'd1, 1'b1, 1'b1);
    send_graph(28'h0000001);
    send_graph(GraphWordW'($urandom));
    drain();
    configure(4'd15, 1'b1, 1'b1);
    send_graph(GraphWordW'($urandom));
    drain();
    configure(4'd9, 1'b0, 1'b1);
    send_graph('1);
    drain();
  endtask

  // empty, complete, single-edge and striped graphs; single-edge and striped in both pair orders
  task automatic test_field_extremes;
    configure(4'd4, 1'b0, 1'b1);
    send_graph('0);
    send_graph('1);
    send_graph(28'h0000001);
    send_graph(28'h0000020);  // top used bit at four nodes
    send_graph(28'hAAAAAAA);
    send_graph(28'h5555555);
    drain();
    configure(4'd5, 1'b1, 1'b0);
    send_graph(28'h0000200);  // top used bit at five nodes
    send_graph(28'h0000001);
    send_graph(28'h00002AA);
    send_graph(GraphWordW'($urandom));
    drain();
  endtask

  // unknown index is dropped; only bit 0 of the order register counts
  task automatic test_unmapped_index;
    configure(4'd3, 1'b1, 1'b0);
    set_reg(CfgUnmapped, '1);
    set_reg(CfgLowerOrder, 4'b1110);
    send_graph(GraphWordW'($urandom));
    send_graph(GraphWordW'($urandom));
    drain();
  endtask

  // random settings per phase; mostly small graphs to keep the run short
  task automatic test_random_graphs;
    label_t                canon_form;
    logic [GraphWordW-1:0] word;
    logic [CfgDataW-1:0]   nc;
    int                    pick;
    for (int phase = 0; phase < 10; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) nc = 4'd7;
      else if (pick == 1) nc = CfgDataW'($urandom_range(0, 1));
      else nc = CfgDataW'($urandom_range(2, 6));
      idle_pct = (phase == 4) ? 0 : 13;  // one phase runs without any idling
      configure(nc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int n = 0; n < 10; n++) begin
        word = GraphWordW'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          // send a graph already in canonical form, junk above the used bits
          canon_form = label_graph(word, node_count_q, lower_order_q, invert_perm_q);
          word = (word & ~pair_mask(node_count_q)) | canon_form.canon;
        end
        send_graph(word);
      end
      drain();
    end
    idle_pct = 13;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_node_count_clamp();
    test_field_extremes();
    test_unmapped_index();
    test_random_graphs();

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending_labels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
